### rtl/core/command_line_tokenizer_defines.svh
// Assertion macros used by the command line tokenizer checker.
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH

// Checks a property on every clock edge outside of reset.
`define CMDTOK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define CMDTOK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### rtl/core/cmdtok_pkg.sv
// Types, constants and codes shared by the command line tokenizer modules.
`timescale 1ns / 1ps

package cmdtok_pkg;

    localparam int MAX_BACKSLASH_RUN_DEF = 32;
    localparam int ARG_SLOTS_DEF         = 64;

    // Wide enough for the longest backslash run allowed by default (32).
    localparam int BS_W = 6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [7:0] TERMINATOR_RESET = 8'h0A;
    localparam logic [6:0] MAX_ARGS_RESET   = 7'd64;

    localparam logic CFG_TERMINATOR = 1'b0;
    localparam logic CFG_MAX_ARGS   = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_ARG_END = 2'd1,
        KIND_CMD_END = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_ARG  = 2'd1,
        PH_HELD = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t          phase;
        logic            quoted;
        logic            inner;
        logic [BS_W-1:0] bs;
        logic [6:0]      arg_counter;
        logic            has_bytes;
        logic            discarding;
    } tok_state_t;

    // Results caused by one character, in emission order: a held argument
    // end, a run of backslashes, then up to two closing results.
    typedef struct packed {
        logic            pre_en;
        logic [5:0]      pre_idx;
        logic [BS_W-1:0] run;
        logic            run_ovf;
        logic [5:0]      idx;
        logic            t0_en;
        kind_t           t0_kind;
        logic [7:0]      t0_byte;
        logic            t1_en;
        logic [6:0]      cnt;
    } plan_t;

endpackage

### rtl/core/cmdtok_step.sv
// Per-character parser: next state and the list of results one character causes.
`timescale 1ns / 1ps

module cmdtok_step import cmdtok_pkg::*; #(
    parameter int MAX_BACKSLASH_RUN = MAX_BACKSLASH_RUN_DEF,
    parameter int ARG_SLOTS         = ARG_SLOTS_DEF
) (
    input  logic [7:0] ch,
    input  logic [7:0] terminator,
    input  logic [6:0] max_args,
    input  tok_state_t cur,
    output tok_state_t nxt,
    output plan_t      plan
);

    localparam logic [BS_W-1:0] RUN_LIMIT = BS_W'(MAX_BACKSLASH_RUN);
    localparam logic [6:0]      SLOT_LIM  = 7'(ARG_SLOTS);

    logic [6:0]      lim;
    logic            is_term;
    logic            is_ws;
    logic            has_eff;
    logic [5:0]      cur_idx;
    logic [BS_W-1:0] half_run;

    always_comb begin
        lim      = (max_args == 7'd0) ? 7'd1 : ((max_args > SLOT_LIM) ? SLOT_LIM : max_args);
        is_term  = (ch == CH_NUL) || (ch == terminator);
        is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                   (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
        cur_idx  = (cur.arg_counter == 7'd0) ? 6'd0 : 6'(cur.arg_counter - 7'd1);
        half_run = cur.bs >> 1;
        has_eff  = 1'b0;

        nxt          = cur;
        plan         = '0;
        plan.idx     = cur_idx;
        plan.pre_idx = cur_idx;
        plan.t0_kind = KIND_BYTE;

        if (is_term) begin
            if (cur.discarding) begin
                nxt.discarding = 1'b0;
            end else begin
                plan.t1_en = 1'b1;
                plan.cnt   = cur.arg_counter;
                if (cur.phase == PH_ARG) begin
                    plan.run = cur.bs;
                    if (cur.has_bytes || (cur.bs != '0)) begin
                        plan.t0_en   = 1'b1;
                        plan.t0_kind = KIND_ARG_END;
                    end else if (cur.arg_counter != 7'd0) begin
                        plan.cnt = cur.arg_counter - 7'd1;
                    end
                end else if ((cur.phase == PH_HELD) && (cur.arg_counter != 7'd0)) begin
                    plan.cnt = cur.arg_counter - 7'd1;
                end
                nxt.phase       = PH_SKIP;
                nxt.quoted      = 1'b0;
                nxt.inner       = 1'b0;
                nxt.bs          = '0;
                nxt.arg_counter = 7'd0;
                nxt.has_bytes   = 1'b0;
            end
        end else if (cur.discarding) begin
            nxt = cur;
        end else if (cur.phase == PH_ARG) begin
            if (ch == CH_BSLASH) begin
                if (cur.bs >= RUN_LIMIT) begin
                    plan.run      = cur.bs;
                    plan.run_ovf  = 1'b1;
                    nxt.has_bytes = 1'b1;
                    nxt.bs        = BS_W'(1);
                end else begin
                    nxt.bs = cur.bs + BS_W'(1);
                end
            end else if (ch == CH_QUOTE) begin
                plan.run      = half_run;
                nxt.bs        = '0;
                has_eff       = cur.has_bytes || (half_run != '0);
                nxt.has_bytes = has_eff;
                if (cur.bs[0]) begin
                    plan.t0_en    = 1'b1;
                    plan.t0_byte  = CH_QUOTE;
                    nxt.has_bytes = 1'b1;
                end else if (cur.quoted) begin
                    plan.t0_en   = has_eff;
                    plan.t0_kind = KIND_ARG_END;
                    nxt.phase    = has_eff ? PH_SKIP : PH_HELD;
                    nxt.quoted   = 1'b0;
                    nxt.inner    = 1'b0;
                end else begin
                    nxt.inner = ~cur.inner;
                end
            end else begin
                plan.run      = cur.bs;
                nxt.bs        = '0;
                has_eff       = cur.has_bytes || (cur.bs != '0);
                nxt.has_bytes = has_eff;
                if (is_ws && !cur.quoted && !cur.inner) begin
                    plan.t0_en   = has_eff;
                    plan.t0_kind = KIND_ARG_END;
                    nxt.phase    = has_eff ? PH_SKIP : PH_HELD;
                    nxt.quoted   = 1'b0;
                    nxt.inner    = 1'b0;
                end else begin
                    plan.t0_en    = 1'b1;
                    plan.t0_byte  = ch;
                    nxt.has_bytes = 1'b1;
                end
            end
        end else if (!is_ws) begin
            if (cur.arg_counter >= lim) begin
                plan.t1_en = 1'b1;
                plan.cnt   = cur.arg_counter;
                if ((cur.phase == PH_HELD) && (cur.arg_counter != 7'd0)) begin
                    plan.cnt = cur.arg_counter - 7'd1;
                end
                nxt.phase       = PH_SKIP;
                nxt.quoted      = 1'b0;
                nxt.inner       = 1'b0;
                nxt.bs          = '0;
                nxt.arg_counter = 7'd0;
                nxt.has_bytes   = 1'b0;
                nxt.discarding  = 1'b1;
            end else begin
                plan.pre_en     = (cur.phase == PH_HELD);
                plan.idx        = cur.arg_counter[5:0];
                nxt.arg_counter = cur.arg_counter + 7'd1;
                nxt.phase       = PH_ARG;
                nxt.has_bytes   = 1'b0;
                nxt.inner       = 1'b0;
                nxt.bs          = '0;
                nxt.quoted      = (ch == CH_QUOTE);
                if (ch == CH_BSLASH) begin
                    nxt.bs = BS_W'(1);
                end else if (ch != CH_QUOTE) begin
                    plan.t0_en    = 1'b1;
                    plan.t0_byte  = ch;
                    nxt.has_bytes = 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/command_line_tokenizer.sv
// Top level of the command line tokenizer: parser state, result list and output register.
`timescale 1ns / 1ps

// Usage: one character per transaction on the s_ channel (s_valid, s_ready,
// s_ch). Each character updates the parser state at once and leaves a short
// list of results, which are sent one per cycle on the m_ channel as
// argument bytes, argument ends and end-of-command transactions; m_last
// marks the final result of a character. A character that causes no result
// leaves the result list empty and sends nothing on the m_ channel.
// Results of an accepted character are stored in the result list and then
// moved into the output register one at a time. A character causes up to
// MAX_BACKSLASH_RUN plus 2 results (34 by default, for a terminator after a
// long backslash run); ordinary text runs at one character per cycle while
// the receiver is ready, and the next character is accepted in the cycle the
// previous list drains.
// A stalled receiver holds the output register; the result list and the
// input side then wait with it. Configuration writes (terminator_char and
// max_args) are taken every cycle and are meant for idle periods only.
// Reset clears the parser state, the result list and the output valid.
module command_line_tokenizer import cmdtok_pkg::*; #(
    parameter int MAX_BACKSLASH_RUN = MAX_BACKSLASH_RUN_DEF,
    parameter int ARG_SLOTS         = ARG_SLOTS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic [5:0] m_arg_index,
    output logic [6:0] m_arg_count,
    output logic       m_run_overflow,
    output logic       m_last
);

    logic [7:0] terminator_reg;
    logic [6:0] max_args_reg;
    tok_state_t state_reg, state_next;
    plan_t      plan_reg, plan_step, plan_after;

    logic       m_valid_reg;
    kind_t      m_kind_reg, kind_sel;
    logic [7:0] m_byte_reg, byte_sel;
    logic [5:0] m_idx_reg, idx_sel;
    logic [6:0] m_cnt_reg, cnt_sel;
    logic       m_ovf_reg, ovf_sel;
    logic       m_last_reg;

    logic plan_busy, out_free, emit, remaining, accept;

    cmdtok_step #(
        .MAX_BACKSLASH_RUN(MAX_BACKSLASH_RUN),
        .ARG_SLOTS        (ARG_SLOTS)
    ) u_step (
        .ch        (s_ch),
        .terminator(terminator_reg),
        .max_args  (max_args_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .plan      (plan_step)
    );

    always_comb begin
        plan_busy  = plan_reg.pre_en || (plan_reg.run != '0) || plan_reg.t0_en || plan_reg.t1_en;
        out_free   = !m_valid_reg || m_ready;
        emit       = plan_busy && out_free;
        plan_after = plan_reg;
        kind_sel   = KIND_BYTE;
        byte_sel   = 8'd0;
        idx_sel    = plan_reg.idx;
        cnt_sel    = 7'd0;
        ovf_sel    = 1'b0;
        remaining  = 1'b0;
        if (plan_reg.pre_en) begin
            kind_sel          = KIND_ARG_END;
            idx_sel           = plan_reg.pre_idx;
            remaining         = (plan_reg.run != '0) || plan_reg.t0_en || plan_reg.t1_en;
            plan_after.pre_en = 1'b0;
        end else if (plan_reg.run != '0) begin
            byte_sel       = CH_BSLASH;
            ovf_sel        = plan_reg.run_ovf;
            remaining      = (plan_reg.run != BS_W'(1)) || plan_reg.t0_en || plan_reg.t1_en;
            plan_after.run = plan_reg.run - BS_W'(1);
        end else if (plan_reg.t0_en) begin
            kind_sel         = plan_reg.t0_kind;
            byte_sel         = (plan_reg.t0_kind == KIND_BYTE) ? plan_reg.t0_byte : 8'd0;
            remaining        = plan_reg.t1_en;
            plan_after.t0_en = 1'b0;
        end else begin
            kind_sel         = KIND_CMD_END;
            idx_sel          = 6'd0;
            cnt_sel          = plan_reg.cnt;
            plan_after.t1_en = 1'b0;
        end
        s_ready = !plan_busy || (out_free && !remaining);
        accept  = s_valid && s_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            terminator_reg <= TERMINATOR_RESET;
            max_args_reg   <= MAX_ARGS_RESET;
            state_reg      <= '0;
            plan_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TERMINATOR) begin
                    terminator_reg <= cfg_data;
                end else begin
                    max_args_reg <= cfg_data[6:0];
                end
            end
            if (accept) begin
                state_reg <= state_next;
                plan_reg  <= plan_step;
            end else if (emit) begin
                plan_reg <= plan_after;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind_reg <= kind_sel;
            m_byte_reg <= byte_sel;
            m_idx_reg  <= idx_sel;
            m_cnt_reg  <= cnt_sel;
            m_ovf_reg  <= ovf_sel;
            m_last_reg <= !remaining;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_arg_index    = m_idx_reg;
    assign m_arg_count    = m_cnt_reg;
    assign m_run_overflow = m_ovf_reg;
    assign m_last         = m_last_reg;

endmodule

### rtl/core/cmdtok_checker.sv
// Port-level assertions for the command line tokenizer and their binding.
`timescale 1ns / 1ps
`include "command_line_tokenizer_defines.svh"

module cmdtok_checker import cmdtok_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_out_byte,
    input logic [5:0] m_arg_index,
    input logic [6:0] m_arg_count,
    input logic       m_run_overflow,
    input logic       m_last
);

    // An end of command is always the final result of its character.
    `CMDTOK_ASSERT(a_cmd_end_last, m_valid && (m_kind == KIND_CMD_END) |-> m_last, "end of command without last")

    // Only argument bytes carry a byte value or the overflow flag.
    `CMDTOK_ASSERT(a_end_clean, m_valid && (m_kind != KIND_BYTE) |-> (m_out_byte == 8'd0) && !m_run_overflow, "end transaction carries byte data")

    // The argument count is shown on end of command only, and an end of command has index zero.
    `CMDTOK_ASSERT(a_count_only_cmd, m_valid |-> ((m_kind == KIND_CMD_END) ? (m_arg_index == 6'd0) : (m_arg_count == 7'd0)), "count or index on wrong transaction kind")

    // A stalled result transaction keeps its contents.
    `CMDTOK_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_out_byte) && $stable(m_last), "stalled result changed")

    // Nothing is offered right after reset.
    `CMDTOK_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind command_line_tokenizer cmdtok_checker u_cmdtok_checker (.*);
